// File: hw/rtl/hcn_pkg.sv
// ----------------------------------------------------------------------------
// hcn_pkg
// Shared widths, stage counts and sideband type of the cell normals pipeline.
// ----------------------------------------------------------------------------
package hcn_pkg;

   localparam int unsigned HEIGHT_W   = 16;
   localparam int unsigned SPACING_W  = 15;
   localparam int unsigned COMP_W     = 16;
   localparam int unsigned DIFF_W     = 19;
   localparam int unsigned SQUARE_W   = 38;
   localparam int unsigned RAD_W      = 62;
   localparam int unsigned ROOT_W     = 31;
   localparam int unsigned REM_W      = 33;
   localparam int unsigned SHIFT_W    = 5;
   localparam int unsigned QUOT_W     = 16;
   localparam int unsigned LANES      = 6;
   localparam int unsigned TRIS       = 2;
   localparam int unsigned SQRT_STEPS = 31;
   localparam int unsigned DIV_STEPS  = 16;
   localparam int unsigned FRONT      = 4;
   localparam int unsigned STAGES     = FRONT + SQRT_STEPS + DIV_STEPS + 1;
   localparam logic [COMP_W-1:0] Q14_ONE = 16'd16384;

   typedef struct packed {
      logic [LANES-1:0] neg;
      logic             degen;
      logic             last;
   } side_type;

endpackage

// File: hw/rtl/heightfield_cell_normals_unit.sv
// ----------------------------------------------------------------------------
// heightfield_cell_normals_unit
// Unit normals of the upper and lower triangles of one height grid cell.
//
// req_* carries one cell: four Q3.12 corner heights in tdata, the end-of-pass
// mark in tlast. rsp_* returns six Q1.14 normal components in tdata, the
// degenerate flag in tuser and the end-of-pass mark in tlast. csr_* writes
// the Q1.14 grid spacing; write it only while no cell is in flight.
// One cell enters per cycle while req_tready is high. The depth comes from
// the square root (one root bit per stage, 31 stages) followed by the
// division (one quotient bit per stage, 16 stages), plus four front stages
// and the output register.
// When rsp_tready is low while the output register holds a result, the
// whole pipeline holds and req_tready drops; nothing is lost or doubled.
// Reset empties the pipeline and sets the spacing to 8192 (0.5).
// ----------------------------------------------------------------------------
module heightfield_cell_normals_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // height_here, height_next_row, height_next_col, height_diagonal
   input  logic [63:0]  req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // upper_normal_x, upper_normal_y, upper_normal_z,
   // lower_normal_x, lower_normal_y, lower_normal_z
   output logic [95:0]  rsp_tdata,
   // degenerate
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [14:0]  csr_wdata
);
   import hcn_pkg::*;

   logic                 adv;
   logic [STAGES-1:0]    vld_ff;
   logic [SPACING_W-1:0] spacing_ff;
   side_type             side_ff [0:STAGES-1];
   side_type             side_in;

   logic [DIFF_W-1:0]    mag_in   [0:LANES-1];
   logic [DIFF_W-1:0]    maga_ff  [0:LANES-1];
   logic [DIFF_W-1:0]    magb_ff  [0:LANES-1];
   logic [DIFF_W-1:0]    magc_ff  [0:LANES-1];
   logic [SQUARE_W-1:0]  sq_ff    [0:LANES-1];
   logic [SQUARE_W-1:0]  sum_ff   [0:TRIS-1];

   logic [RAD_W-1:0]     sx_ff    [0:SQRT_STEPS][0:TRIS-1];
   logic [REM_W-1:0]     srem_ff  [0:SQRT_STEPS][0:TRIS-1];
   logic [ROOT_W-1:0]    sroot_ff [0:SQRT_STEPS][0:TRIS-1];
   logic [ROOT_W-1:0]    sm_ff    [0:SQRT_STEPS][0:LANES-1];

   logic [ROOT_W-1:0]    drem_ff  [1:DIV_STEPS][0:LANES-1];
   logic [QUOT_W-1:0]    dq_ff    [1:DIV_STEPS][0:LANES-1];
   logic [ROOT_W-1:0]    dlen_ff  [1:DIV_STEPS][0:TRIS-1];

   logic [95:0]          out_ff;
   logic [95:0]          out_in;

   logic signed [16:0]   diff [0:3];
   logic signed [18:0]   dsc  [0:3];

   assign adv        = !vld_ff[STAGES-1] || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = side_ff[STAGES-1].degen;
   assign rsp_tlast  = side_ff[STAGES-1].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= SPACING_W'(8192);
         vld_ff     <= '0;
      end else begin
         if (csr_valid) begin
            spacing_ff <= csr_wdata;
         end
         if (adv) begin
            vld_ff <= {vld_ff[STAGES-2:0], req_tvalid};
         end
      end
   end

   // front stage: height differences, magnitudes and signs
   always_comb begin
      diff[0] = 17'(signed'(req_tdata[31:16])) - 17'(signed'(req_tdata[15:0]));
      diff[1] = 17'(signed'(req_tdata[47:32])) - 17'(signed'(req_tdata[15:0]));
      diff[2] = 17'(signed'(req_tdata[31:16])) - 17'(signed'(req_tdata[63:48]));
      diff[3] = 17'(signed'(req_tdata[47:32])) - 17'(signed'(req_tdata[63:48]));
      for (int i = 0; i < 4; i++) begin
         dsc[i] = {diff[i], 2'b00};
      end
      mag_in[0] = dsc[0][18] ? DIFF_W'(-dsc[0]) : DIFF_W'(dsc[0]);
      mag_in[2] = dsc[1][18] ? DIFF_W'(-dsc[1]) : DIFF_W'(dsc[1]);
      mag_in[3] = dsc[2][18] ? DIFF_W'(-dsc[2]) : DIFF_W'(dsc[2]);
      mag_in[5] = dsc[3][18] ? DIFF_W'(-dsc[3]) : DIFF_W'(dsc[3]);
      mag_in[1] = DIFF_W'(spacing_ff);
      mag_in[4] = DIFF_W'(spacing_ff);
      side_in.neg[0] = !dsc[0][18] && (dsc[0] != '0);
      side_in.neg[1] = 1'b0;
      side_in.neg[2] = !dsc[1][18] && (dsc[1] != '0);
      side_in.neg[3] = dsc[2][18];
      side_in.neg[4] = 1'b0;
      side_in.neg[5] = dsc[3][18];
      side_in.degen  = (spacing_ff == '0);
      side_in.last   = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         for (int l = 0; l < LANES; l++) begin
            maga_ff[l] <= mag_in[l];
            magb_ff[l] <= maga_ff[l];
            magc_ff[l] <= magb_ff[l];
            sq_ff[l]   <= maga_ff[l] * maga_ff[l];
         end
         for (int t = 0; t < TRIS; t++) begin
            sum_ff[t] <= sq_ff[3*t] + sq_ff[3*t+1] + sq_ff[3*t+2];
         end
      end
   end

   // normalize the squared length into [2^60, 2^62)
   generate
      for (genvar t = 0; t < TRIS; t++) begin : g_norm
         logic [5:0]         msb;
         logic [SHIFT_W-1:0] k;
         always_comb begin
            msb = '0;
            for (int b = 0; b < SQUARE_W; b++) begin
               if (sum_ff[t][b]) begin
                  msb = 6'(b);
               end
            end
            k = SHIFT_W'((6'd61 - msb) >> 1);
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               sx_ff[0][t]       <= RAD_W'(sum_ff[t]) << {k, 1'b0};
               srem_ff[0][t]     <= '0;
               sroot_ff[0][t]    <= '0;
               sm_ff[0][3*t]     <= ROOT_W'(magc_ff[3*t]) << k;
               sm_ff[0][3*t+1]   <= ROOT_W'(magc_ff[3*t+1]) << k;
               sm_ff[0][3*t+2]   <= ROOT_W'(magc_ff[3*t+2]) << k;
            end
         end
      end

      // square root, one result bit per stage
      for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
         for (genvar t = 0; t < TRIS; t++) begin : g_tri
            logic [REM_W+1:0] cur;
            logic [REM_W+1:0] trial;
            logic             take;
            always_comb begin
               cur   = {srem_ff[j][t], sx_ff[j][t][RAD_W-1 -: 2]};
               trial = {1'b0, 1'b0, sroot_ff[j][t], 2'b01};
               take  = (cur >= trial);
            end
            always_ff @(posedge clock) begin
               if (adv) begin
                  sx_ff[j+1][t]    <= sx_ff[j][t] << 2;
                  srem_ff[j+1][t]  <= take ? REM_W'(cur - trial) : REM_W'(cur);
                  sroot_ff[j+1][t] <= {sroot_ff[j][t][ROOT_W-2:0], take};
               end
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               for (int l = 0; l < LANES; l++) begin
                  sm_ff[j+1][l] <= sm_ff[j][l];
               end
            end
         end
      end

      // division by the root, one quotient bit per stage
      for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [ROOT_W:0]    t_w;
            logic [ROOT_W-1:0]  len;
            logic [QUOT_W-1:0]  q_prev;
            logic               bit_w;
            always_comb begin
               if (i == 1) begin
                  t_w    = {1'b0, sm_ff[SQRT_STEPS][l]};
                  len    = sroot_ff[SQRT_STEPS][l/3];
                  q_prev = '0;
               end else begin
                  t_w    = {drem_ff[(i > 1) ? i-1 : 1][l], 1'b0};
                  len    = dlen_ff[(i > 1) ? i-1 : 1][l/3];
                  q_prev = dq_ff[(i > 1) ? i-1 : 1][l];
               end
               bit_w = (t_w >= {1'b0, len});
            end
            always_ff @(posedge clock) begin
               if (adv) begin
                  drem_ff[i][l] <= bit_w ? ROOT_W'(t_w - {1'b0, len}) : ROOT_W'(t_w);
                  dq_ff[i][l]   <= {q_prev[QUOT_W-2:0], bit_w};
               end
            end
         end
         for (genvar t = 0; t < TRIS; t++) begin : g_len
            always_ff @(posedge clock) begin
               if (adv) begin
                  dlen_ff[i][t] <= (i == 1) ? sroot_ff[SQRT_STEPS][t]
                                            : dlen_ff[(i > 1) ? i-1 : 1][t];
               end
            end
         end
      end
   endgenerate

   // round half up, saturate, apply sign; a degenerate cell gives all zeros
   always_comb begin
      logic [QUOT_W:0]   rnd;
      logic [COMP_W-1:0] mag;
      for (int l = 0; l < LANES; l++) begin
         rnd = ({1'b0, dq_ff[DIV_STEPS][l]} + 17'd1) >> 1;
         mag = (rnd[QUOT_W-1:0] > Q14_ONE) ? Q14_ONE : rnd[QUOT_W-1:0];
         if (side_ff[STAGES-2].degen) begin
            out_in[l*COMP_W +: COMP_W] = '0;
         end else if (side_ff[STAGES-2].neg[l]) begin
            out_in[l*COMP_W +: COMP_W] = COMP_W'(-mag);
         end else begin
            out_in[l*COMP_W +: COMP_W] = mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

endmodule
